>>> rtl/ctsc_pkg.sv
// Package for the clock time-set controller: mode codes, limits and BCD step helpers.
package ctsc_pkg;

  typedef enum logic [1:0] {
    MODE_HOUR    = 2'd0,
    MODE_MINUTE  = 2'd1,
    MODE_WEEKDAY = 2'd2
  } mode_t;

  localparam logic       OP_START    = 1'b0;
  localparam logic       OP_UPDATE   = 1'b1;
  localparam logic [7:0] HOUR_TOP    = 8'h23;
  localparam logic [7:0] MINUTE_TOP  = 8'h59;
  localparam logic [2:0] DAY_FIRST   = 3'd1;
  localparam logic [2:0] DAY_LAST    = 3'd7;
  localparam logic [3:0] BLINK_HOUR  = 4'b0011;
  localparam logic [3:0] BLINK_MIN   = 4'b1100;
  localparam logic [3:0] BLINK_NONE  = 4'b0000;
  localparam logic [3:0] DIGIT_NINE  = 4'd9;
  localparam logic [3:0] DIGIT_ZERO  = 4'd0;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 32;

  // Step a two-digit BCD value up by one. A low digit above nine keeps
  // counting as a five-bit value that is merged into the high digit field.
  function automatic logic [7:0] bcd_up(input logic [7:0] v);
    logic [4:0] lo;
    logic [3:0] hi;
    hi = v[7:4];
    if (v[3:0] == DIGIT_NINE) begin
      lo = 5'd0;
      hi = hi + 4'd1;
    end else begin
      lo = {1'b0, v[3:0]} + 5'd1;
    end
    return {hi, 4'b0000} | {3'b000, lo};
  endfunction

  // Step a two-digit BCD value down by one with a borrow from the high digit.
  function automatic logic [7:0] bcd_down(input logic [7:0] v);
    logic [3:0] lo;
    logic [3:0] hi;
    hi = v[7:4];
    if (v[3:0] == DIGIT_ZERO) begin
      lo = DIGIT_NINE;
      hi = hi - 4'd1;
    end else begin
      lo = v[3:0] - 4'd1;
    end
    return {hi, lo};
  endfunction

  function automatic logic [7:0] wrap_up(input logic [7:0] v, input logic [7:0] top);
    return (v < top) ? bcd_up(v) : 8'h00;
  endfunction

  function automatic logic [7:0] wrap_down(input logic [7:0] v, input logic [7:0] top);
    return (v != 8'h00) ? bcd_down(v) : top;
  endfunction

endpackage

>>> rtl/clock_time_set_controller_top.sv
// Top level of the clock time-set controller: mode sequencer, BCD steppers and result register.
//
// The controller walks a user through setting a clock in three modes: hour, minute and weekday.
// A start item (tuser op = 0) loads the BCD hour, BCD minute and weekday and selects hour mode.
// An update item (op = 1) carries short-press flags taken in priority up, down, set: up and down
// step the field being edited with wrap (hour 00..23, minute 00..59, weekday 1..7), set advances
// to the next mode, and set in weekday mode raises commit while the mode stays weekday. Each
// accepted item yields exactly one result item in the next cycle, with the mode, the values, the
// tube and day-lamp blink masks and a copy of the alarm flags. The block takes one item every
// clock cycle: all of the step logic sits between the input port and the state and result
// registers, and the single result register is refilled in the same cycle that its item is
// taken downstream, so throughput is only limited by back-pressure on the result side.
module clock_time_set_controller_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, low bit up: load_hour_bcd[5:0], load_minute_bcd[12:6], load_weekday[15:13],
  // press_up[16], press_down[17], press_set[18], alarm_active[22:19], zero[23]
  input  logic [ctsc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: op[0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata, low bit up: hour_bcd[5:0], minute_bcd[12:6], weekday[15:13], digit_blink[19:16],
  // weekday_blink[20], alarm_lamps[24:21], commit[25], zero[31:26]
  output logic [ctsc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser: mode[1:0]
  output logic [1:0]                         m_axis_tuser
);
  import ctsc_pkg::*;

  // Input fields.
  logic       op;
  logic [5:0] load_hour_bcd;
  logic [6:0] load_minute_bcd;
  logic [2:0] load_weekday;
  logic       press_up;
  logic       press_down;
  logic       press_set;
  logic [3:0] alarm_active;

  assign op              = s_axis_tuser;
  assign load_hour_bcd   = s_axis_tdata[5:0];
  assign load_minute_bcd = s_axis_tdata[12:6];
  assign load_weekday    = s_axis_tdata[15:13];
  assign press_up        = s_axis_tdata[16];
  assign press_down      = s_axis_tdata[17];
  assign press_set       = s_axis_tdata[18];
  assign alarm_active    = s_axis_tdata[22:19];

  // Edit state. Hour and minute never leave six and seven bits: an up step is only taken
  // below the top value, so the carry into the high digit stays inside the field.
  mode_t      edit_mode, edit_mode_next;
  logic [5:0] hour_value, hour_value_next;
  logic [6:0] minute_value, minute_value_next;
  logic [2:0] day_value, day_value_next;
  logic       commit_next;

  // Result register.
  logic       out_valid;
  mode_t      out_mode;
  logic [5:0] out_hour;
  logic [6:0] out_minute;
  logic [2:0] out_day;
  logic [3:0] out_digit_blink;
  logic       out_weekday_blink;
  logic [3:0] out_alarm_lamps;
  logic       out_commit;

  logic       accept;
  logic [3:0] digit_blink_next;
  logic       weekday_blink_next;
  logic [7:0] hour_up, hour_down, minute_up, minute_down;

  // The result register is free when empty or when its item leaves in this cycle.
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign hour_up     = wrap_up({2'b00, hour_value}, HOUR_TOP);
  assign hour_down   = wrap_down({2'b00, hour_value}, HOUR_TOP);
  assign minute_up   = wrap_up({1'b0, minute_value}, MINUTE_TOP);
  assign minute_down = wrap_down({1'b0, minute_value}, MINUTE_TOP);

  // Next state: start loads, update steps the field of the current mode.
  always_comb begin
    edit_mode_next    = edit_mode;
    hour_value_next   = hour_value;
    minute_value_next = minute_value;
    day_value_next    = day_value;
    commit_next       = 1'b0;
    if (op == OP_START) begin
      edit_mode_next    = MODE_HOUR;
      hour_value_next   = load_hour_bcd;
      minute_value_next = load_minute_bcd;
      day_value_next    = load_weekday;
    end else begin
      case (edit_mode)
        MODE_HOUR: begin
          if (press_up) begin
            hour_value_next = hour_up[5:0];
          end else if (press_down) begin
            hour_value_next = hour_down[5:0];
          end else if (press_set) begin
            edit_mode_next = MODE_MINUTE;
          end
        end
        MODE_MINUTE: begin
          if (press_up) begin
            minute_value_next = minute_up[6:0];
          end else if (press_down) begin
            minute_value_next = minute_down[6:0];
          end else if (press_set) begin
            edit_mode_next = MODE_WEEKDAY;
          end
        end
        MODE_WEEKDAY: begin
          // A weekday of zero steps to Monday on up and to Sunday on down.
          if (press_up) begin
            day_value_next = (day_value >= DAY_LAST) ? DAY_FIRST : day_value + 3'd1;
          end else if (press_down) begin
            day_value_next = (day_value <= DAY_FIRST) ? DAY_LAST : day_value - 3'd1;
          end else if (press_set) begin
            commit_next = 1'b1;
          end
        end
        default: begin
          // An unused mode code falls back to hour mode and ignores the buttons.
          edit_mode_next = MODE_HOUR;
        end
      endcase
    end
  end

  // Outputs that follow from the mode after the step.
  always_comb begin
    case (edit_mode_next)
      MODE_HOUR: begin
        digit_blink_next   = BLINK_HOUR;
        weekday_blink_next = 1'b0;
      end
      MODE_MINUTE: begin
        digit_blink_next   = BLINK_MIN;
        weekday_blink_next = 1'b0;
      end
      MODE_WEEKDAY: begin
        digit_blink_next   = BLINK_NONE;
        weekday_blink_next = 1'b1;
      end
      default: begin
        digit_blink_next   = BLINK_NONE;
        weekday_blink_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edit_mode    <= MODE_HOUR;
      hour_value   <= '0;
      minute_value <= '0;
      day_value    <= DAY_FIRST;
    end else if (accept) begin
      edit_mode    <= edit_mode_next;
      hour_value   <= hour_value_next;
      minute_value <= minute_value_next;
      day_value    <= day_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_mode          <= edit_mode_next;
      out_hour          <= hour_value_next;
      out_minute        <= minute_value_next;
      out_day           <= day_value_next;
      out_digit_blink   <= digit_blink_next;
      out_weekday_blink <= weekday_blink_next;
      out_alarm_lamps   <= alarm_active;
      out_commit        <= commit_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_mode;
  assign m_axis_tdata  = {6'b000000, out_commit, out_alarm_lamps, out_weekday_blink,
                          out_digit_blink, out_day, out_minute, out_hour};

  // A commit is only ever reported from weekday mode.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_commit) |-> (out_mode == MODE_WEEKDAY))
    else $error("commit reported outside weekday mode");

  // A start item always produces an hour-mode result without commit in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_START)) |=>
      (m_axis_tvalid && (m_axis_tuser == MODE_HOUR) && !out_commit))
    else $error("start item did not produce an hour-mode result");

  // Day-lamp blink agrees with the reported mode, and the tube blink mask is the hour mask in hour mode.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((out_weekday_blink == (out_mode == MODE_WEEKDAY)) &&
                       ((out_mode != MODE_HOUR) || (out_digit_blink == BLINK_HOUR))))
    else $error("blink masks disagree with mode");

  // An item that is not a start leaves the loaded values untouched unless up or down is pressed.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_UPDATE) && !press_up && !press_down) |=>
      ((hour_value == $past(hour_value)) && (minute_value == $past(minute_value)) &&
       (day_value == $past(day_value))))
    else $error("values changed without an up or down press");

endmodule
